// ===== src/ryc_pkg.sv =====
// Shared types and constants for the 2x2 RGB to YCbCr 4:2:0 converter.
// Used by ryc_lane, ryc_merge and rgb_to_ycbcr_420_block_top; no dependencies.
package ryc_pkg;

    localparam int GAIN_W    = 16;
    localparam int PIX_W     = 8;
    localparam int PROD_W    = GAIN_W + PIX_W;
    // Wide enough for three products plus the offset at any gain setting, signed.
    localparam int SUM_W     = 28;
    localparam int NUM_LANES = 4;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_LUMA_RED   = 3'd0,
        REG_LUMA_GREEN = 3'd1,
        REG_LUMA_BLUE  = 3'd2,
        REG_CB_RED     = 3'd3,
        REG_CB_GREEN   = 3'd4,
        REG_CB_BLUE    = 3'd5,
        REG_CR_RED     = 3'd6,
        REG_CR_GREEN   = 3'd7
    } reg_idx_t;

    localparam logic [GAIN_W-1:0] RST_LUMA_RED   = 16'd2105;
    localparam logic [GAIN_W-1:0] RST_LUMA_GREEN = 16'd4129;
    localparam logic [GAIN_W-1:0] RST_LUMA_BLUE  = 16'd803;
    localparam logic [GAIN_W-1:0] RST_CB_RED     = 16'd1212;
    localparam logic [GAIN_W-1:0] RST_CB_GREEN   = 16'd2384;
    localparam logic [GAIN_W-1:0] RST_CB_BLUE    = 16'd3596;
    localparam logic [GAIN_W-1:0] RST_CR_RED     = 16'd3596;
    localparam logic [GAIN_W-1:0] RST_CR_GREEN   = 16'd3015;

    typedef struct packed {
        logic [GAIN_W-1:0] luma_red;
        logic [GAIN_W-1:0] luma_green;
        logic [GAIN_W-1:0] luma_blue;
        logic [GAIN_W-1:0] cb_red;
        logic [GAIN_W-1:0] cb_green;
        logic [GAIN_W-1:0] cb_blue;
        logic [GAIN_W-1:0] cr_red;
        logic [GAIN_W-1:0] cr_green;
    } gains_t;

    // Pipeline load strobes from the top-level flow control to each lane.
    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } lane_ctrl_t;

endpackage

// ===== src/ryc_lane.sv =====
// One pixel lane: nine gain products, then offset sums, floor shift and clamp.
// Depends on ryc_pkg.
module ryc_lane #(
    parameter int FRACTION_BITS      = 13,
    parameter int RED_DIFF_BLUE_GAIN = 582
) (
    input  logic                          clk,
    input  ryc_pkg::lane_ctrl_t           ctrl,
    input  ryc_pkg::gains_t               gains,
    input  logic [ryc_pkg::PIX_W-1:0]     red,
    input  logic [ryc_pkg::PIX_W-1:0]     green,
    input  logic [ryc_pkg::PIX_W-1:0]     blue,
    output logic [ryc_pkg::PIX_W-1:0]     luma,
    output logic [ryc_pkg::PIX_W-1:0]     cb,
    output logic [ryc_pkg::PIX_W-1:0]     cr
);

    localparam int SUM_W  = ryc_pkg::SUM_W;
    localparam int PROD_W = ryc_pkg::PROD_W;
    localparam int PIX_W  = ryc_pkg::PIX_W;
    localparam logic [SUM_W-1:0] Y_OFS = SUM_W'(16 << FRACTION_BITS);
    localparam logic [SUM_W-1:0] C_OFS = SUM_W'(128 << FRACTION_BITS);
    localparam logic [ryc_pkg::GAIN_W-1:0] CR_BLUE = ryc_pkg::GAIN_W'(RED_DIFF_BLUE_GAIN);

    logic [PROD_W-1:0] y_r_reg, y_g_reg, y_b_reg;
    logic [PROD_W-1:0] cb_r_reg, cb_g_reg, cb_b_reg;
    logic [PROD_W-1:0] cr_r_reg, cr_g_reg, cr_b_reg;
    logic [SUM_W-1:0]  y_sum, cb_sum, cr_sum;
    logic [PIX_W-1:0]  luma_reg, cb_reg, cr_reg;

    // Negative sums clamp to zero; otherwise shift and saturate at 255.
    function automatic logic [PIX_W-1:0] shift_clamp(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] q;
        q = s >> FRACTION_BITS;
        if (s[SUM_W-1])
            return '0;
        else if (|q[SUM_W-1:PIX_W])
            return '1;
        else
            return q[PIX_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            y_r_reg  <= gains.luma_red   * red;
            y_g_reg  <= gains.luma_green * green;
            y_b_reg  <= gains.luma_blue  * blue;
            cb_r_reg <= gains.cb_red     * red;
            cb_g_reg <= gains.cb_green   * green;
            cb_b_reg <= gains.cb_blue    * blue;
            cr_r_reg <= gains.cr_red     * red;
            cr_g_reg <= gains.cr_green   * green;
            cr_b_reg <= CR_BLUE          * blue;
        end
    end

    always_comb
    begin
        y_sum  = Y_OFS + SUM_W'(y_r_reg) + SUM_W'(y_g_reg) + SUM_W'(y_b_reg);
        cb_sum = C_OFS - SUM_W'(cb_r_reg) - SUM_W'(cb_g_reg) + SUM_W'(cb_b_reg);
        cr_sum = C_OFS + SUM_W'(cr_r_reg) - SUM_W'(cr_g_reg) - SUM_W'(cr_b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_sum)
        begin
            luma_reg <= shift_clamp(y_sum);
            cb_reg   <= shift_clamp(cb_sum);
            cr_reg   <= shift_clamp(cr_sum);
        end
    end

    assign luma = luma_reg;
    assign cb   = cb_reg;
    assign cr   = cr_reg;

endmodule

// ===== src/ryc_merge.sv =====
// Merge stage: floor average of the four lane chroma values, plus output register.
// Depends on ryc_pkg.
module ryc_merge (
    input  logic                                          clk,
    input  logic                                          load,
    input  logic [ryc_pkg::NUM_LANES-1:0][ryc_pkg::PIX_W-1:0] luma_in,
    input  logic [ryc_pkg::NUM_LANES-1:0][ryc_pkg::PIX_W-1:0] cb_in,
    input  logic [ryc_pkg::NUM_LANES-1:0][ryc_pkg::PIX_W-1:0] cr_in,
    output logic [ryc_pkg::NUM_LANES-1:0][ryc_pkg::PIX_W-1:0] luma_out,
    output logic [ryc_pkg::PIX_W-1:0]                     cb_out,
    output logic [ryc_pkg::PIX_W-1:0]                     cr_out
);

    localparam int PIX_W = ryc_pkg::PIX_W;
    localparam int ACC_W = PIX_W + 2;

    logic [ACC_W-1:0] cb_total, cr_total;
    logic [ryc_pkg::NUM_LANES-1:0][PIX_W-1:0] luma_reg;
    logic [PIX_W-1:0] cb_reg, cr_reg;

    always_comb
    begin
        cb_total = ACC_W'(cb_in[0]) + ACC_W'(cb_in[1]) + ACC_W'(cb_in[2]) + ACC_W'(cb_in[3]);
        cr_total = ACC_W'(cr_in[0]) + ACC_W'(cr_in[1]) + ACC_W'(cr_in[2]) + ACC_W'(cr_in[3]);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            luma_reg <= luma_in;
            cb_reg   <= cb_total[ACC_W-1:2];
            cr_reg   <= cr_total[ACC_W-1:2];
        end
    end

    assign luma_out = luma_reg;
    assign cb_out   = cb_reg;
    assign cr_out   = cr_reg;

endmodule

// ===== src/rgb_to_ycbcr_420_block_top.sv =====
// Top level of the 2x2 RGB to YCbCr 4:2:0 converter: gain registers, flow control,
// four pixel lanes and the chroma merge stage. Depends on ryc_pkg, ryc_lane, ryc_merge.
//
// Takes one 2x2 RGB block per clock and returns one result per clock once the
// pipe is full and out_ready is high. The three stages are the per-lane gain
// multipliers, the per-lane offset sum with floor shift and 0..255 clamp, and the
// chroma average with the output register. Any stage that holds an item moves on
// as soon as the stage after it frees up, so in_ready stays high while out_ready
// is high. Eight of the nine gains come from 16-bit registers written through
// cfg_write/cfg_index/cfg_data (the Cr blue gain is RED_DIFF_BLUE_GAIN); they
// reset to BT.601 values and should only be changed while the pipe is empty.
module rgb_to_ycbcr_420_block_top #(
    parameter int FRACTION_BITS      = 13,
    parameter int RED_DIFF_BLUE_GAIN = 582
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ryc_pkg::IDX_W-1:0]           cfg_index,
    input  logic [ryc_pkg::GAIN_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          red_top_left,
    input  logic [7:0]                          red_top_right,
    input  logic [7:0]                          red_bottom_left,
    input  logic [7:0]                          red_bottom_right,
    input  logic [7:0]                          green_top_left,
    input  logic [7:0]                          green_top_right,
    input  logic [7:0]                          green_bottom_left,
    input  logic [7:0]                          green_bottom_right,
    input  logic [7:0]                          blue_top_left,
    input  logic [7:0]                          blue_top_right,
    input  logic [7:0]                          blue_bottom_left,
    input  logic [7:0]                          blue_bottom_right,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          luma_top_left,
    output logic [7:0]                          luma_top_right,
    output logic [7:0]                          luma_bottom_left,
    output logic [7:0]                          luma_bottom_right,
    output logic [7:0]                          blue_chroma,
    output logic [7:0]                          red_chroma
);

    localparam int LANES = ryc_pkg::NUM_LANES;
    localparam int PIX_W = ryc_pkg::PIX_W;

    ryc_pkg::gains_t     gains_reg;
    ryc_pkg::lane_ctrl_t lane_ctrl;
    logic prod_valid_reg, sum_valid_reg, out_valid_reg;
    logic adv_prod, adv_sum, adv_out;

    logic [LANES-1:0][PIX_W-1:0] red_px, green_px, blue_px;
    logic [LANES-1:0][PIX_W-1:0] lane_luma, lane_cb, lane_cr, luma_q;

    // Gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.luma_red   <= ryc_pkg::RST_LUMA_RED;
            gains_reg.luma_green <= ryc_pkg::RST_LUMA_GREEN;
            gains_reg.luma_blue  <= ryc_pkg::RST_LUMA_BLUE;
            gains_reg.cb_red     <= ryc_pkg::RST_CB_RED;
            gains_reg.cb_green   <= ryc_pkg::RST_CB_GREEN;
            gains_reg.cb_blue    <= ryc_pkg::RST_CB_BLUE;
            gains_reg.cr_red     <= ryc_pkg::RST_CR_RED;
            gains_reg.cr_green   <= ryc_pkg::RST_CR_GREEN;
        end
        else if (cfg_write)
        begin
            case (ryc_pkg::reg_idx_t'(cfg_index))
                ryc_pkg::REG_LUMA_RED:   gains_reg.luma_red   <= cfg_data;
                ryc_pkg::REG_LUMA_GREEN: gains_reg.luma_green <= cfg_data;
                ryc_pkg::REG_LUMA_BLUE:  gains_reg.luma_blue  <= cfg_data;
                ryc_pkg::REG_CB_RED:     gains_reg.cb_red     <= cfg_data;
                ryc_pkg::REG_CB_GREEN:   gains_reg.cb_green   <= cfg_data;
                ryc_pkg::REG_CB_BLUE:    gains_reg.cb_blue    <= cfg_data;
                ryc_pkg::REG_CR_RED:     gains_reg.cr_red     <= cfg_data;
                ryc_pkg::REG_CR_GREEN:   gains_reg.cr_green   <= cfg_data;
                default:                 gains_reg            <= gains_reg;
            endcase
        end
    end

    // A stage advances when it is empty or the next stage advances.
    assign adv_out  = !out_valid_reg || out_ready;
    assign adv_sum  = !sum_valid_reg || adv_out;
    assign adv_prod = !prod_valid_reg || adv_sum;
    assign in_ready = adv_prod;

    assign lane_ctrl.load_prod = in_valid && adv_prod;
    assign lane_ctrl.load_sum  = prod_valid_reg && adv_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv_prod)
                prod_valid_reg <= in_valid;
            if (adv_sum)
                sum_valid_reg <= prod_valid_reg;
            if (adv_out)
                out_valid_reg <= sum_valid_reg;
        end
    end

    assign red_px   = {red_bottom_right, red_bottom_left, red_top_right, red_top_left};
    assign green_px = {green_bottom_right, green_bottom_left, green_top_right, green_top_left};
    assign blue_px  = {blue_bottom_right, blue_bottom_left, blue_top_right, blue_top_left};

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        ryc_lane #(
            .FRACTION_BITS      (FRACTION_BITS),
            .RED_DIFF_BLUE_GAIN (RED_DIFF_BLUE_GAIN)
        ) u_lane (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .gains (gains_reg),
            .red   (red_px[i]),
            .green (green_px[i]),
            .blue  (blue_px[i]),
            .luma  (lane_luma[i]),
            .cb    (lane_cb[i]),
            .cr    (lane_cr[i])
        );
    end

    ryc_merge u_merge (
        .clk      (clk),
        .load     (sum_valid_reg && adv_out),
        .luma_in  (lane_luma),
        .cb_in    (lane_cb),
        .cr_in    (lane_cr),
        .luma_out (luma_q),
        .cb_out   (blue_chroma),
        .cr_out   (red_chroma)
    );

    assign out_valid         = out_valid_reg;
    assign luma_top_left     = luma_q[0];
    assign luma_top_right    = luma_q[1];
    assign luma_bottom_left  = luma_q[2];
    assign luma_bottom_right = luma_q[3];

endmodule
